// ===== src/midi_event_frame_placer_top_defines.svh =====
// Assertion macros used by the frame placer top level.
`ifndef MIDI_EVENT_FRAME_PLACER_TOP_DEFINES_SVH
`define MIDI_EVENT_FRAME_PLACER_TOP_DEFINES_SVH

// Checks that the consequent holds whenever the antecedent holds.
`define MEFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame placer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MEFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame placer check failed");

`endif

// ===== src/mefp_pkg.sv =====
// Types and constants of the MIDI event frame placer.
package mefp_pkg;
  localparam int TIME_W  = 64;
  localparam int RATE_W  = 19;
  localparam int FC_W    = 14;
  localparam int OFF_W   = 13;
  localparam int CNT_W   = 32;
  localparam int FNS_W   = 44;
  localparam int PROD_W  = FNS_W + RATE_W;
  localparam int DEN_W   = 32;

  // Division by two seconds in nanoseconds: the numerator is shifted right by ten and
  // multiplied by ceil(2^55 / 5^9), which is 2^34 plus RCP_C_LO.
  localparam int RCP_DROP  = 10;
  localparam int RCP_W     = 34;
  localparam int RCP_C_W   = 31;
  localparam int RCP_P_W   = RCP_W + RCP_C_W;
  localparam int RCP_HI_SH = 34;
  localparam int RCP_S_W   = 69;
  localparam int RCP_SH    = 55;

  localparam logic [FC_W-1:0]    FRAMES_MAX   = 14'd8192;
  localparam logic [RATE_W-1:0]  RATE_RESET   = 19'd48000;
  localparam logic [TIME_W-1:0]  NS_PER_SEC   = 64'd1000000000;
  localparam logic [RCP_C_W-1:0] RCP_C_LO     = 31'd1266874890;
  localparam logic [CNT_W-1:0]   CNT_MAX      = 32'hFFFF_FFFF;

  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_COLLECT = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] time_ns;
    logic [7:0]        status;
    logic [7:0]        data1;
    logic [7:0]        data2;
  } msg_t;
endpackage

// ===== src/mefp_if.sv =====
// Channel interfaces of the MIDI event frame placer.
interface mefp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mefp_pkg::TIME_W-1:0]   time_ns;
  logic [7:0]                    status;
  logic [7:0]                    data1;
  logic [7:0]                    data2;
  logic [mefp_pkg::FC_W-1:0]     frame_count;
  modport source (output valid, mode, time_ns, status, data1, data2, frame_count,
                  input ready);
  modport sink (input valid, mode, time_ns, status, data1, data2, frame_count,
                output ready);
endinterface

interface mefp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          has_event;
  logic [mefp_pkg::OFF_W-1:0]    frame_offset;
  logic [7:0]                    out_status;
  logic [7:0]                    out_data1;
  logic [7:0]                    out_data2;
  logic                          was_late;
  logic                          last;
  logic [mefp_pkg::CNT_W-1:0]    dropped_total;
  logic [mefp_pkg::CNT_W-1:0]    late_total;
  modport source (output valid, has_event, frame_offset, out_status, out_data1,
                  out_data2, was_late, last, dropped_total, late_total, input ready);
  modport sink (input valid, has_event, frame_offset, out_status, out_data1,
                out_data2, was_late, last, dropped_total, late_total, output ready);
endinterface

interface mefp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mefp_pkg::RATE_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/mefp_mem.sv =====
// Message store: one write port and one registered read port.
module mefp_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mefp_pkg::msg_t        wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output mefp_pkg::msg_t        rd_data
);
  mefp_pkg::msg_t mem_r [DEPTH];
  mefp_pkg::msg_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== src/mefp_smul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
module mefp_smul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mefp_pkg::FNS_W-1:0]    a,
  input  logic [mefp_pkg::RATE_W-1:0]   b,
  output logic                          done,
  output logic [mefp_pkg::PROD_W-1:0]   prod
);
  logic [mefp_pkg::PROD_W-1:0] a_r;
  logic [mefp_pkg::PROD_W-1:0] acc_r;
  logic [mefp_pkg::RATE_W-1:0] b_r;
  logic [$clog2(mefp_pkg::RATE_W+1)-1:0] cnt_r;
  logic busy_r;
  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= mefp_pkg::PROD_W'(a);
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r <= {a_r[mefp_pkg::PROD_W-2:0], 1'b0};
        b_r <= {1'b0, b_r[mefp_pkg::RATE_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(mefp_pkg::RATE_W+1))'(mefp_pkg::RATE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== src/mefp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mefp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mefp_pkg::TIME_W-1:0]   num,
  input  logic [mefp_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [mefp_pkg::TIME_W-1:0]   quot
);
  logic [mefp_pkg::TIME_W-1:0] num_r;
  logic [mefp_pkg::DEN_W-1:0]  den_r;
  logic [mefp_pkg::DEN_W-1:0]  rem_r;
  logic [$clog2(mefp_pkg::TIME_W+1)-1:0] cnt_r;
  logic busy_r;
  logic done_r;
  logic [mefp_pkg::DEN_W:0] trial;
  logic                     fits;

  assign trial = {rem_r, num_r[mefp_pkg::TIME_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? mefp_pkg::DEN_W'(trial - {1'b0, den_r})
                      : trial[mefp_pkg::DEN_W-1:0];
        num_r <= {num_r[mefp_pkg::TIME_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(mefp_pkg::TIME_W+1))'(mefp_pkg::TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = num_r;
endmodule

// ===== src/midi_event_frame_placer_top.sv =====
// Top level of the MIDI event frame placer: control sequencer and counters.
// A push request is written to the message store, or dropped and counted if the store is
// full. A collect request first divides the block length by the sample rate in the serial
// divider, then checks the held message. The store is then drained one message at a time:
// each message is read and checked, and one at or beyond the end of the block is held for
// the next collect. A late message is placed at offset zero; one inside the block goes
// through the serial multiplier and a reciprocal multiplication by one over two seconds.
// New requests are taken only between collects.
module midi_event_frame_placer_top #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  mefp_in_if.sink       in_ch,
  mefp_out_if.source    out_ch,
  mefp_cfg_if.sink      cfg_ch
);
  `include "midi_event_frame_placer_top_defines.svh"

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BDIV, ST_HELD, ST_RD, ST_CHK, ST_PLACE, ST_MUL, ST_RMUL, ST_RSUM, ST_PUSH,
    ST_FIN
  } state_t;

  state_t state_r;
  logic [mefp_pkg::RATE_W-1:0] rate_r;
  logic [AW-1:0] rp_r, wp_r;
  logic [FW-1:0] fill_r;
  logic [mefp_pkg::CNT_W-1:0] drop_cnt_r, late_cnt_r;
  mefp_pkg::msg_t held_r, cur_r;
  logic held_v_r;
  logic [mefp_pkg::TIME_W-1:0] start_r, end_r;
  logic [mefp_pkg::FC_W-1:0] frames_r;
  logic [mefp_pkg::FNS_W-1:0] fns_r;
  logic mul_go_r, div_go_r;
  logic [mefp_pkg::TIME_W-1:0] div_num_r;
  logic [mefp_pkg::DEN_W-1:0] div_den_r;
  logic [mefp_pkg::RCP_W-1:0] rcp_m_r;
  logic [mefp_pkg::RCP_P_W-1:0] rcp_p_r;

  logic [mefp_pkg::OFF_W-1:0] new_off_r;
  logic new_late_r;
  logic [mefp_pkg::CNT_W-1:0] new_lt_r;
  logic stg_v_r;
  mefp_pkg::msg_t stg_msg_r;
  logic [mefp_pkg::OFF_W-1:0] stg_off_r;
  logic stg_late_r;
  logic [mefp_pkg::CNT_W-1:0] stg_lt_r;

  logic out_v_r, o_has_r, o_late_r, o_last_r;
  logic [mefp_pkg::OFF_W-1:0] o_off_r;
  logic [7:0] o_st_r, o_d1_r, o_d2_r;
  logic [mefp_pkg::CNT_W-1:0] o_dt_r, o_lt_r;

  logic in_acc, slot_free, fifo_full, mem_wr, mem_rd;
  logic [mefp_pkg::FC_W-1:0] frames_in;
  logic [mefp_pkg::TIME_W-1:0] delta;
  logic [mefp_pkg::TIME_W-1:0] off_num;
  logic [mefp_pkg::RCP_S_W-1:0] rcp_sum;
  logic [mefp_pkg::OFF_W-1:0] last_frame;
  logic [mefp_pkg::CNT_W-1:0] late_inc;
  mefp_pkg::msg_t wr_msg, rd_msg;
  logic mul_done, div_done;
  logic [mefp_pkg::PROD_W-1:0] prod;
  logic [mefp_pkg::TIME_W-1:0] quot;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_v_r || out_ch.ready;
  assign fifo_full    = (fill_r == FW'(FIFO_DEPTH));
  assign frames_in    = (in_ch.frame_count > mefp_pkg::FRAMES_MAX) ? mefp_pkg::FRAMES_MAX
                                                                   : in_ch.frame_count;
  assign delta        = cur_r.time_ns - start_r;
  assign off_num      = mefp_pkg::TIME_W'({prod, 1'b0}) + mefp_pkg::NS_PER_SEC;
  assign rcp_sum      = mefp_pkg::RCP_S_W'({rcp_m_r, {mefp_pkg::RCP_HI_SH{1'b0}}}) +
                        mefp_pkg::RCP_S_W'(rcp_p_r);
  assign last_frame   = mefp_pkg::OFF_W'(frames_r - 1'b1);
  assign late_inc     = (late_cnt_r == mefp_pkg::CNT_MAX) ? late_cnt_r : late_cnt_r + 1'b1;
  assign mem_wr       = in_acc && (in_ch.mode == mefp_pkg::MODE_PUSH) && !fifo_full;
  assign mem_rd       = (state_r == ST_RD) && (fill_r != '0);

  always_comb begin
    wr_msg.time_ns = in_ch.time_ns;
    wr_msg.status  = in_ch.status;
    wr_msg.data1   = in_ch.data1;
    wr_msg.data2   = in_ch.data2;
  end

  mefp_mem #(.DEPTH(FIFO_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .wr_en(mem_wr), .wr_addr(wp_r), .wr_data(wr_msg),
    .rd_en(mem_rd), .rd_addr(rp_r), .rd_data(rd_msg)
  );

  mefp_smul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r), .a(delta[mefp_pkg::FNS_W-1:0]),
    .b(rate_r), .done(mul_done), .prod(prod)
  );

  mefp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .num(div_num_r), .den(div_den_r),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rate_r     <= mefp_pkg::RATE_RESET;
      rp_r       <= '0;
      wp_r       <= '0;
      fill_r     <= '0;
      drop_cnt_r <= '0;
      late_cnt_r <= '0;
      held_v_r   <= 1'b0;
      held_r     <= '0;
      mul_go_r   <= 1'b0;
      div_go_r   <= 1'b0;
      stg_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        rate_r <= cfg_ch.data;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.mode == mefp_pkg::MODE_PUSH) begin
              if (fifo_full) begin
                if (drop_cnt_r != mefp_pkg::CNT_MAX) begin
                  drop_cnt_r <= drop_cnt_r + 1'b1;
                end
              end else begin
                wp_r   <= (wp_r == AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
                fill_r <= fill_r + 1'b1;
              end
            end else begin
              start_r  <= in_ch.time_ns;
              frames_r <= frames_in;
              fns_r    <= mefp_pkg::FNS_W'(frames_in) *
                          mefp_pkg::FNS_W'(mefp_pkg::NS_PER_SEC);
              if (frames_in == '0 || rate_r == '0) begin
                state_r <= ST_FIN;
              end else begin
                div_num_r <= mefp_pkg::TIME_W'(mefp_pkg::FNS_W'(frames_in) *
                                               mefp_pkg::FNS_W'(mefp_pkg::NS_PER_SEC));
                div_den_r <= mefp_pkg::DEN_W'(rate_r);
                div_go_r  <= 1'b1;
                state_r   <= ST_BDIV;
              end
            end
          end
        end
        ST_BDIV: begin
          if (div_done) begin
            end_r   <= start_r + quot;
            state_r <= ST_HELD;
          end
        end
        ST_HELD: begin
          if (!held_v_r) begin
            state_r <= ST_RD;
          end else if (held_r.time_ns >= end_r) begin
            state_r <= ST_FIN;
          end else begin
            cur_r    <= held_r;
            held_v_r <= 1'b0;
            state_r  <= ST_PLACE;
          end
        end
        ST_RD: begin
          if (fill_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            rp_r    <= (rp_r == AW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
            fill_r  <= fill_r - 1'b1;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (rd_msg.time_ns >= end_r) begin
            held_r   <= rd_msg;
            held_v_r <= 1'b1;
            state_r  <= ST_FIN;
          end else begin
            cur_r   <= rd_msg;
            state_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          new_lt_r <= late_cnt_r;
          if (cur_r.time_ns <= start_r) begin
            new_late_r <= 1'b1;
            new_off_r  <= '0;
            late_cnt_r <= late_inc;
            new_lt_r   <= late_inc;
            state_r    <= ST_PUSH;
          end else if (delta > mefp_pkg::TIME_W'(fns_r)) begin
            new_late_r <= 1'b0;
            new_off_r  <= last_frame;
            state_r    <= ST_PUSH;
          end else begin
            new_late_r <= 1'b0;
            mul_go_r   <= 1'b1;
            state_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            if (off_num >= mefp_pkg::TIME_W'({fns_r, 1'b0})) begin
              new_off_r <= last_frame;
              state_r   <= ST_PUSH;
            end else begin
              rcp_m_r <= off_num[mefp_pkg::RCP_DROP +: mefp_pkg::RCP_W];
              state_r <= ST_RMUL;
            end
          end
        end
        ST_RMUL: begin
          rcp_p_r <= rcp_m_r * mefp_pkg::RCP_C_LO;
          state_r <= ST_RSUM;
        end
        ST_RSUM: begin
          new_off_r <= rcp_sum[mefp_pkg::RCP_SH +: mefp_pkg::OFF_W];
          state_r   <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!stg_v_r || slot_free) begin
            if (stg_v_r) begin
              out_v_r  <= 1'b1;
              o_has_r  <= 1'b1;
              o_off_r  <= stg_off_r;
              o_st_r   <= stg_msg_r.status;
              o_d1_r   <= stg_msg_r.data1;
              o_d2_r   <= stg_msg_r.data2;
              o_late_r <= stg_late_r;
              o_last_r <= 1'b0;
              o_dt_r   <= drop_cnt_r;
              o_lt_r   <= stg_lt_r;
            end
            stg_v_r    <= 1'b1;
            stg_msg_r  <= cur_r;
            stg_off_r  <= new_off_r;
            stg_late_r <= new_late_r;
            stg_lt_r   <= new_lt_r;
            state_r    <= ST_RD;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_v_r  <= 1'b1;
            o_has_r  <= stg_v_r;
            o_off_r  <= stg_v_r ? stg_off_r : '0;
            o_st_r   <= stg_v_r ? stg_msg_r.status : 8'd0;
            o_d1_r   <= stg_v_r ? stg_msg_r.data1 : 8'd0;
            o_d2_r   <= stg_v_r ? stg_msg_r.data2 : 8'd0;
            o_late_r <= stg_v_r && stg_late_r;
            o_last_r <= 1'b1;
            o_dt_r   <= drop_cnt_r;
            o_lt_r   <= stg_v_r ? stg_lt_r : late_cnt_r;
            stg_v_r  <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.has_event     = o_has_r;
  assign out_ch.frame_offset  = o_off_r;
  assign out_ch.out_status    = o_st_r;
  assign out_ch.out_data1     = o_d1_r;
  assign out_ch.out_data2     = o_d2_r;
  assign out_ch.was_late      = o_late_r;
  assign out_ch.last          = o_last_r;
  assign out_ch.dropped_total = o_dt_r;
  assign out_ch.late_total    = o_lt_r;

  `MEFP_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(FIFO_DEPTH))
  `MEFP_ASSERT_NOW(a_idle_no_stage, clk, rst_n, state_r == ST_IDLE, !stg_v_r)
  `MEFP_ASSERT_NEXT(a_full_drop_keeps_fill, clk, rst_n,
    in_acc && in_ch.mode == mefp_pkg::MODE_PUSH && fifo_full, $stable(fill_r))
  `MEFP_ASSERT_NOW(a_rd_not_empty, clk, rst_n, state_r == ST_CHK, $past(fill_r) != '0)
endmodule
